### design/register_alu_instruction_executor_assert.svh
// ----------------------------------------------------------------------------
// Register ALU instruction executor: assertion macros
// Clocked on clk and disabled during reset (rst_n low). Define ASSERT_OFF to
// compile every check away.
// ----------------------------------------------------------------------------
`ifndef REGISTER_ALU_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_ALU_INSTRUCTION_EXECUTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define RAIE_ASSERT_IMPL(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("raie: same-cycle check failed");

// Next-cycle implication.
`define RAIE_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("raie: next-cycle check failed");

`else

`define RAIE_ASSERT_IMPL(label, trig, cons)
`define RAIE_ASSERT_NEXT(label, trig, cons)

`endif

`endif

### design/raie_pkg.sv
// ----------------------------------------------------------------------------
// raie_pkg
// Types, command codes and helpers shared by the register ALU executor.
// ----------------------------------------------------------------------------
package raie_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DATA_W    = 32;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [3:0] CMD_IN   = 4'd0;
  localparam logic [3:0] CMD_MOV  = 4'd1;
  localparam logic [3:0] CMD_XCHG = 4'd2;
  localparam logic [3:0] CMD_ADD  = 4'd3;
  localparam logic [3:0] CMD_SUB  = 4'd4;
  localparam logic [3:0] CMD_MUL  = 4'd5;
  localparam logic [3:0] CMD_DIV  = 4'd6;
  localparam logic [3:0] CMD_MOD  = 4'd7;
  localparam logic [3:0] CMD_AND  = 4'd8;
  localparam logic [3:0] CMD_OR   = 4'd9;
  localparam logic [3:0] CMD_XOR  = 4'd10;
  localparam logic [3:0] CMD_OUT  = 4'd11;

  localparam logic KIND_VALUE    = 1'b0;
  localparam logic KIND_DIV_ZERO = 1'b1;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [2:0]         dest_reg;
    logic [2:0]         src1_reg;
    logic [2:0]         src2_reg;
    logic               three_operand;
    logic signed [31:0] immediate;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
  } out_word_t;

  typedef struct packed {
    logic              en;
    reg_idx_t          addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  // Folds a 3-bit register field into the implemented register range.
  function automatic reg_idx_t reg_index(input logic [2:0] field);
    logic [7:0] v;
    v = {5'd0, field};
    for (int i = 0; i < 4; i++) begin
      if (v >= 8'(NUM_REGS)) begin
        v = v - 8'(NUM_REGS);
      end
    end
    return v[REG_IDX_W-1:0];
  endfunction

endpackage

### design/raie_regfile.sv
// ----------------------------------------------------------------------------
// raie_regfile
// Register file with one write port and two registered read ports. Per-entry
// valid bits make every register read as zero until first written.
// ----------------------------------------------------------------------------
module raie_regfile (
  input  logic                        clk,
  input  logic                        rst_n,
  input  raie_pkg::reg_idx_t          rd_a_addr,
  input  raie_pkg::reg_idx_t          rd_b_addr,
  input  raie_pkg::rf_wr_t            wr,
  output logic [raie_pkg::DATA_W-1:0] rd_a_data,
  output logic [raie_pkg::DATA_W-1:0] rd_b_data
);

  logic [raie_pkg::DATA_W-1:0] mem_r [raie_pkg::NUM_REGS];
  logic [raie_pkg::NUM_REGS-1:0] valid_r;
  logic [raie_pkg::DATA_W-1:0] rd_a_r;
  logic [raie_pkg::DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r <= valid_r[rd_a_addr] ? mem_r[rd_a_addr] : '0;
    rd_b_r <= valid_r[rd_b_addr] ? mem_r[rd_b_addr] : '0;
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

### design/raie_alu.sv
// ----------------------------------------------------------------------------
// raie_alu
// Shared arithmetic unit. Registered add, subtract, multiply and logic;
// signed truncating divide and modulo by a restoring loop, one bit a cycle.
// ----------------------------------------------------------------------------
module raie_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  raie_pkg::alu_req_t          req,
  input  logic [raie_pkg::DATA_W-1:0] opa,
  input  logic [raie_pkg::DATA_W-1:0] opb,
  output raie_pkg::alu_rsp_t          rsp
);

  logic                           div_busy_r;
  logic                           fix_r;
  logic                           done_r;
  logic [raie_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [raie_pkg::DATA_W-1:0]    rem_r;
  logic [raie_pkg::DATA_W-1:0]    quo_r;
  logic [raie_pkg::DATA_W-1:0]    dvs_r;
  logic [raie_pkg::DATA_W-1:0]    result_r;
  logic                           neg_q_r;
  logic                           neg_r_r;
  logic                           want_rem_r;

  logic                           is_div;
  logic [raie_pkg::DATA_W-1:0]    abs_a;
  logic [raie_pkg::DATA_W-1:0]    abs_b;
  logic [raie_pkg::DATA_W:0]      trial;
  logic [raie_pkg::DATA_W:0]      diff;
  logic                           fits;
  logic [raie_pkg::DATA_W-1:0]    simple_res;

  assign is_div = (req.op == raie_pkg::CMD_DIV) || (req.op == raie_pkg::CMD_MOD);
  assign abs_a  = opa[raie_pkg::DATA_W-1] ? (~opa + 1'b1) : opa;
  assign abs_b  = opb[raie_pkg::DATA_W-1] ? (~opb + 1'b1) : opb;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, quo_r[raie_pkg::DATA_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = !diff[raie_pkg::DATA_W];

  always_comb begin
    unique case (req.op)
      raie_pkg::CMD_ADD: simple_res = opa + opb;
      raie_pkg::CMD_SUB: simple_res = opa - opb;
      raie_pkg::CMD_MUL: simple_res = opa * opb;
      raie_pkg::CMD_AND: simple_res = opa & opb;
      raie_pkg::CMD_OR:  simple_res = opa | opb;
      raie_pkg::CMD_XOR: simple_res = opa ^ opb;
      default:           simple_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      fix_r      <= 1'b0;
      done_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= '0;
        if (is_div) begin
          div_busy_r <= 1'b1;
        end else begin
          done_r <= 1'b1;
        end
      end else if (div_busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == raie_pkg::DIV_CNT_W'(raie_pkg::DATA_W - 1)) begin
          div_busy_r <= 1'b0;
          fix_r      <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      if (is_div) begin
        rem_r      <= '0;
        quo_r      <= abs_a;
        dvs_r      <= abs_b;
        neg_q_r    <= opa[raie_pkg::DATA_W-1] ^ opb[raie_pkg::DATA_W-1];
        neg_r_r    <= opa[raie_pkg::DATA_W-1];
        want_rem_r <= (req.op == raie_pkg::CMD_MOD);
      end else begin
        result_r <= simple_res;
      end
    end else if (div_busy_r) begin
      rem_r <= fits ? diff[raie_pkg::DATA_W-1:0] : trial[raie_pkg::DATA_W-1:0];
      quo_r <= {quo_r[raie_pkg::DATA_W-2:0], fits};
    end else if (fix_r) begin
      // Remainder takes the dividend's sign, quotient the sign of the product.
      if (want_rem_r) begin
        result_r <= neg_r_r ? (~rem_r + 1'b1) : rem_r;
      end else begin
        result_r <= neg_q_r ? (~quo_r + 1'b1) : quo_r;
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule

### design/raie_ctrl.sv
// ----------------------------------------------------------------------------
// raie_ctrl
// Instruction sequencer: captures a word, reads operands, drives the shared
// unit and the write port, and holds the result word for the output channel.
// ----------------------------------------------------------------------------
`include "register_alu_instruction_executor_assert.svh"

module raie_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  raie_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output raie_pkg::out_word_t         out_data,
  output raie_pkg::reg_idx_t          rd_a_addr,
  output raie_pkg::reg_idx_t          rd_b_addr,
  input  logic [raie_pkg::DATA_W-1:0] rd_a_data,
  input  logic [raie_pkg::DATA_W-1:0] rd_b_data,
  output raie_pkg::rf_wr_t            wr,
  output raie_pkg::alu_req_t          alu_req,
  input  raie_pkg::alu_rsp_t          rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_BUSY = 3'd3;
  localparam logic [2:0] S_SWAP = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [3:0]          cmd_r;
  raie_pkg::reg_idx_t  d_r;
  raie_pkg::reg_idx_t  s1_r;
  raie_pkg::reg_idx_t  s2_r;
  logic                three_r;
  logic [31:0]         imm_r;
  logic                emit_kind_r;
  logic                emit_kind_nxt;
  logic                out_valid_r;
  raie_pkg::out_word_t out_data_r;
  logic                is_alu;
  logic                slot_free;
  logic                div_zero;

  assign is_alu    = (cmd_r >= raie_pkg::CMD_ADD) && (cmd_r <= raie_pkg::CMD_XOR);
  assign slot_free = !out_valid_r || out_ready;
  assign div_zero  = ((cmd_r == raie_pkg::CMD_DIV) || (cmd_r == raie_pkg::CMD_MOD)) &&
                     (rd_b_data == '0);

  // Three-operand form only applies to arithmetic and logic commands.
  assign rd_a_addr = (three_r && is_alu) ? s1_r : d_r;
  assign rd_b_addr = (three_r && is_alu) ? s2_r : s1_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    emit_kind_nxt = emit_kind_r;
    wr.en         = 1'b0;
    wr.addr       = d_r;
    wr.data       = rsp.result;
    alu_req.start = 1'b0;
    alu_req.op    = cmd_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (cmd_r) inside
          raie_pkg::CMD_IN: begin
            wr.en     = 1'b1;
            wr.data   = imm_r;
            state_nxt = S_IDLE;
          end
          raie_pkg::CMD_MOV: begin
            wr.en     = 1'b1;
            wr.data   = rd_b_data;
            state_nxt = S_IDLE;
          end
          raie_pkg::CMD_XCHG: begin
            wr.en     = 1'b1;
            wr.data   = rd_b_data;
            state_nxt = S_SWAP;
          end
          raie_pkg::CMD_OUT: begin
            emit_kind_nxt = raie_pkg::KIND_VALUE;
            state_nxt     = S_EMIT;
          end
          raie_pkg::CMD_DIV, raie_pkg::CMD_MOD: begin
            if (div_zero) begin
              emit_kind_nxt = raie_pkg::KIND_DIV_ZERO;
              state_nxt     = S_EMIT;
            end else begin
              alu_req.start = 1'b1;
              state_nxt     = S_BUSY;
            end
          end
          raie_pkg::CMD_ADD, raie_pkg::CMD_SUB, raie_pkg::CMD_MUL,
          raie_pkg::CMD_AND, raie_pkg::CMD_OR, raie_pkg::CMD_XOR: begin
            alu_req.start = 1'b1;
            state_nxt     = S_BUSY;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_BUSY: begin
        if (rsp.done) begin
          wr.en     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWAP: begin
        // The operand register still holds the old destination contents.
        wr.en     = 1'b1;
        wr.addr   = s1_r;
        wr.data   = rd_a_data;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    emit_kind_r <= emit_kind_nxt;
    if (in_valid && in_ready) begin
      cmd_r   <= in_data.cmd;
      d_r     <= raie_pkg::reg_index(in_data.dest_reg);
      s1_r    <= raie_pkg::reg_index(in_data.src1_reg);
      s2_r    <= raie_pkg::reg_index(in_data.src2_reg);
      three_r <= in_data.three_operand;
      imm_r   <= in_data.immediate;
    end
    if (state_r == S_EMIT && slot_free) begin
      out_data_r.kind  <= emit_kind_r;
      out_data_r.value <= (emit_kind_r == raie_pkg::KIND_DIV_ZERO) ? '0 : rd_a_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RAIE_ASSERT_NEXT(a_accept_to_read, in_valid && in_ready, state_r == S_READ)
  `RAIE_ASSERT_IMPL(a_start_in_exec, alu_req.start, state_r == S_EXEC)
  `RAIE_ASSERT_IMPL(a_busy_write_on_done, state_r == S_BUSY && wr.en, rsp.done)
  `RAIE_ASSERT_IMPL(a_div_zero_no_write, state_r == S_EXEC && div_zero, !wr.en && !alu_req.start)

endmodule

### design/register_alu_instruction_executor.sv
// ----------------------------------------------------------------------------
// register_alu_instruction_executor: one instruction at a time, ready in idle.
// IN, MOV and XCHG write the register file directly; ADD, SUB, MUL and logic
// use the shared unit, DIV and MOD its restoring loop, or an error word for a
// zero divisor. OUT and error words wait while an earlier word is still held.
// Synchronous reset clears the valid bits, so all registers read as zero.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  raie_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output raie_pkg::out_word_t out_data
);

  raie_pkg::reg_idx_t          rd_a_addr;
  raie_pkg::reg_idx_t          rd_b_addr;
  logic [raie_pkg::DATA_W-1:0] rd_a_data;
  logic [raie_pkg::DATA_W-1:0] rd_b_data;
  raie_pkg::rf_wr_t            wr;
  raie_pkg::alu_req_t          alu_req;
  raie_pkg::alu_rsp_t          alu_rsp;

  raie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .wr        (wr),
    .alu_req   (alu_req),
    .rsp       (alu_rsp)
  );

  raie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr        (wr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  raie_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (rd_a_data),
    .opb   (rd_b_data),
    .rsp   (alu_rsp)
  );

endmodule
